@@ rtl/tdc_pkg.sv @@
// ----------------------------------------------------------------------------
// Tube digit crossfade package
// Shared widths, register codes, reset values and structs of the crossfade
// engine.
// ----------------------------------------------------------------------------
package tdc_pkg;

  localparam int TUBE_COUNT_DEF    = 4;
  localparam int CATHODE_COUNT_DEF = 10;

  localparam int PERIOD_W = 16;
  localparam int LEVEL_W  = 12;
  localparam int FADE_W   = 24;
  localparam int TUBE_W   = 2;
  localparam int DIGIT_W  = 4;

  // The divider handles range + ticks - 1, which needs one bit above the fade.
  localparam int DIV_W = FADE_W + 1;

  localparam int PADDR_W = 4;
  localparam int PDATA_W = 32;

  localparam logic [1:0] REG_PERIOD    = 2'd0;
  localparam logic [1:0] REG_LEVEL_MIN = 2'd1;
  localparam logic [1:0] REG_LEVEL_MAX = 2'd2;

  localparam logic [PERIOD_W-1:0] PERIOD_RST    = 16'd1000;
  localparam logic [LEVEL_W-1:0]  LEVEL_MIN_RST = 12'd0;
  localparam logic [LEVEL_W-1:0]  LEVEL_MAX_RST = 12'd4095;

  localparam logic FUNC_TICK   = 1'b0;
  localparam logic FUNC_SELECT = 1'b1;

  typedef struct packed {
    logic [PERIOD_W-1:0] period;
    logic [LEVEL_W-1:0]  level_min;
    logic [LEVEL_W-1:0]  level_max;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

@@ rtl/tdc_if.sv @@
// ----------------------------------------------------------------------------
// Tube digit crossfade channels
// Valid/ready channels for the request items and the level results.
// ----------------------------------------------------------------------------
interface tdc_in_if;
  logic                         valid;
  logic                         ready;
  logic                         func;
  logic [tdc_pkg::TUBE_W-1:0]   tube;
  logic [tdc_pkg::DIGIT_W-1:0]  digit;
  logic                         blank;
  logic [tdc_pkg::FADE_W-1:0]   fade_time_us;

  modport source (output valid, func, tube, digit, blank, fade_time_us, input ready);
  modport sink (input valid, func, tube, digit, blank, fade_time_us, output ready);
endinterface

interface tdc_out_if;
  logic                         valid;
  logic                         ready;
  logic [tdc_pkg::TUBE_W-1:0]   out_tube;
  logic [tdc_pkg::DIGIT_W-1:0]  out_digit;
  logic [tdc_pkg::LEVEL_W-1:0]  level;
  logic                         last;

  modport source (output valid, out_tube, out_digit, level, last, input ready);
  modport sink (input valid, out_tube, out_digit, level, last, output ready);
endinterface

@@ rtl/tdc_cfg.sv @@
// ----------------------------------------------------------------------------
// Tube digit crossfade configuration registers
// APB-style register file holding tick period and the level limits.
// ----------------------------------------------------------------------------
module tdc_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tdc_pkg::PADDR_W-1:0]   paddr,
  input  logic [tdc_pkg::PDATA_W-1:0]   pwdata,
  output logic [tdc_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output tdc_pkg::cfg_t                 cfg_o
);

  tdc_pkg::cfg_t cfg_q;
  logic [1:0]    reg_idx;
  logic          wr_en;

  assign reg_idx = paddr[3:2];
  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.period    <= tdc_pkg::PERIOD_RST;
      cfg_q.level_min <= tdc_pkg::LEVEL_MIN_RST;
      cfg_q.level_max <= tdc_pkg::LEVEL_MAX_RST;
    end else if (wr_en) begin
      case (reg_idx)
        tdc_pkg::REG_PERIOD:    cfg_q.period    <= pwdata[tdc_pkg::PERIOD_W-1:0];
        tdc_pkg::REG_LEVEL_MIN: cfg_q.level_min <= pwdata[tdc_pkg::LEVEL_W-1:0];
        tdc_pkg::REG_LEVEL_MAX: cfg_q.level_max <= pwdata[tdc_pkg::LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tdc_pkg::REG_PERIOD:    prdata = tdc_pkg::PDATA_W'(cfg_q.period);
      tdc_pkg::REG_LEVEL_MIN: prdata = tdc_pkg::PDATA_W'(cfg_q.level_min);
      tdc_pkg::REG_LEVEL_MAX: prdata = tdc_pkg::PDATA_W'(cfg_q.level_max);
      default:                prdata = '0;
    endcase
  end

  assign cfg_o = cfg_q;

endmodule

@@ rtl/tdc_div.sv @@
// ----------------------------------------------------------------------------
// Tube digit crossfade divider
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tdc_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tdc_pkg::div_req_t req_i,
  output tdc_pkg::div_rsp_t rsp_o
);

  localparam int W     = tdc_pkg::DIV_W;
  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0]     rem_q;
  logic [W-1:0]     quo_q;
  logic [W-1:0]     dvs_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q;
  logic             done_q;

  logic [W:0]   rem_sh;
  logic         ge;
  logic [W-1:0] rem_n;

  // Shift the next dividend bit into the partial remainder and try a subtract.
  assign rem_sh = {rem_q, quo_q[W-1]};
  assign ge     = rem_sh >= {1'b0, dvs_q};
  assign rem_n  = ge ? W'(rem_sh - {1'b0, dvs_q}) : rem_sh[W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNT_W'(1);
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start && !busy_q) begin
      rem_q <= '0;
      quo_q <= req_i.dividend;
      dvs_q <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= rem_n;
      quo_q <= {quo_q[W-2:0], ge};
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

@@ rtl/tdc_seq.sv @@
// ----------------------------------------------------------------------------
// Tube digit crossfade sequencer
// Handles select requests, walks armed tubes on each tick, drives the shared
// divider for the step size and updates the cathode level memory.
// ----------------------------------------------------------------------------
module tdc_seq #(
  parameter int TUBE_COUNT    = tdc_pkg::TUBE_COUNT_DEF,
  parameter int CATHODE_COUNT = tdc_pkg::CATHODE_COUNT_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tdc_pkg::cfg_t     cfg_i,
  tdc_in_if.sink            in_i,
  tdc_out_if.source         out_o,
  output tdc_pkg::div_req_t div_req_o,
  input  tdc_pkg::div_rsp_t div_rsp_i
);

  localparam int LW    = tdc_pkg::LEVEL_W;
  localparam int FW    = tdc_pkg::FADE_W;
  localparam int DW    = tdc_pkg::DIV_W;
  localparam int TW    = (TUBE_COUNT > 1) ? $clog2(TUBE_COUNT) : 1;
  localparam int CW    = $clog2(CATHODE_COUNT);
  localparam int DEPTH = TUBE_COUNT * CATHODE_COUNT;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_TUBE  = 3'd1;
  localparam logic [2:0] S_DIV1  = 3'd2;
  localparam logic [2:0] S_DIV2  = 3'd3;
  localparam logic [2:0] S_RD    = 3'd4;
  localparam logic [2:0] S_UPD   = 3'd5;
  localparam logic [2:0] S_NEXT  = 3'd6;
  localparam logic [2:0] S_FLUSH = 3'd7;

  logic [2:0]  state_q, state_d;
  logic [TW-1:0] t_q;
  logic [CW-1:0] c_q;
  logic [LW-1:0] step_q;
  logic          active_q;

  logic [TUBE_COUNT-1:0] armed_q;
  logic [TUBE_COUNT-1:0] tgt_on_q;
  logic [CW-1:0]         tgt_dig_q [TUBE_COUNT];
  logic [FW-1:0]         fade_q [TUBE_COUNT];

  logic [LW-1:0]    level_mem [DEPTH];
  logic [DEPTH-1:0] lvl_vld_q;
  logic [LW-1:0]    rd_data_q;
  logic             rd_vld_q;

  logic                        pend_vld_q;
  logic [tdc_pkg::TUBE_W-1:0]  pend_tube_q;
  logic [tdc_pkg::DIGIT_W-1:0] pend_digit_q;
  logic [LW-1:0]               pend_level_q;

  logic                        out_vld_q;
  logic [tdc_pkg::TUBE_W-1:0]  out_tube_q;
  logic [tdc_pkg::DIGIT_W-1:0] out_digit_q;
  logic [LW-1:0]               out_level_q;
  logic                        out_last_q;

  logic                 in_acc;
  logic [TW-1:0]        sel_tube;
  logic                 sel_ok;
  logic                 sel_on;
  logic [15:0]          period_eff;
  logic [LW-1:0]        range;
  logic [FW-1:0]        ticks;
  logic [AW-1:0]        addr;
  logic                 rising;
  logic [LW-1:0]        v;
  logic [LW:0]          sum_up;
  logic [LW:0]          lim_dn;
  logic [LW-1:0]        nv;
  logic                 stepped;
  logic                 nv_active;
  logic                 out_free;
  logic                 upd_stall;
  logic                 upd_go;
  logic                 t_last;
  logic                 c_last;
  logic                 load_out;

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign sel_tube   = TW'(in_i.tube);
  assign sel_ok     = int'(in_i.tube) < TUBE_COUNT;
  assign sel_on     = !in_i.blank && (int'(in_i.digit) < CATHODE_COUNT);

  assign period_eff = (cfg_i.period == '0) ? 16'd1 : cfg_i.period;
  assign range      = (cfg_i.level_max > cfg_i.level_min) ?
                      (cfg_i.level_max - cfg_i.level_min) : '0;
  assign ticks      = div_rsp_i.quotient[FW-1:0];

  assign addr   = AW'(int'(t_q) * CATHODE_COUNT + int'(c_q));
  assign t_last = (t_q == TW'(TUBE_COUNT - 1));
  assign c_last = (c_q == CW'(CATHODE_COUNT - 1));

  // A level never written still reads as its reset value of zero.
  assign rising = tgt_on_q[t_q] && (tgt_dig_q[t_q] == c_q);
  assign v      = rd_vld_q ? rd_data_q : '0;
  assign sum_up = {1'b0, v} + {1'b0, step_q};
  assign lim_dn = {1'b0, cfg_i.level_min} + {1'b0, step_q};

  always_comb begin
    nv      = v;
    stepped = 1'b0;
    if (rising) begin
      if (v <= cfg_i.level_max) begin
        stepped = 1'b1;
        nv      = (sum_up >= {1'b0, cfg_i.level_max}) ? cfg_i.level_max : sum_up[LW-1:0];
      end
    end else begin
      if (v >= cfg_i.level_min) begin
        stepped = 1'b1;
        nv      = ({1'b0, v} <= lim_dn) ? cfg_i.level_min : v - step_q;
      end
    end
  end

  assign nv_active = (nv > cfg_i.level_min) && (nv < cfg_i.level_max);

  // The newest result waits in the pending slot so that the last flag can be
  // set once the tick is known to produce nothing more.
  assign out_free  = !out_vld_q || out_o.ready;
  assign upd_stall = stepped && pend_vld_q && !out_free;
  assign upd_go    = (state_q == S_UPD) && !upd_stall;
  assign load_out  = pend_vld_q && out_free &&
                     (((state_q == S_UPD) && stepped) || (state_q == S_FLUSH));

  always_comb begin
    div_req_o.start    = 1'b0;
    div_req_o.dividend = DW'(fade_q[t_q]);
    div_req_o.divisor  = DW'(period_eff);
    if (state_q == S_TUBE) begin
      div_req_o.start = armed_q[t_q];
    end else if (state_q == S_DIV1) begin
      // Ceiling division: (range + ticks - 1) / ticks.
      div_req_o.start    = div_rsp_i.done && (ticks != '0);
      div_req_o.dividend = DW'(range) + DW'(ticks) - DW'(1);
      div_req_o.divisor  = DW'(ticks);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_acc && (in_i.func == tdc_pkg::FUNC_TICK)) state_d = S_TUBE;
      end
      S_TUBE: state_d = armed_q[t_q] ? S_DIV1 : S_NEXT;
      S_DIV1: begin
        if (div_rsp_i.done) state_d = (ticks == '0) ? S_RD : S_DIV2;
      end
      S_DIV2: begin
        if (div_rsp_i.done) state_d = S_RD;
      end
      S_RD:   state_d = S_UPD;
      S_UPD: begin
        if (!upd_stall) state_d = c_last ? S_NEXT : S_RD;
      end
      S_NEXT: state_d = t_last ? S_FLUSH : S_TUBE;
      S_FLUSH: begin
        if (!pend_vld_q || out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      t_q        <= '0;
      c_q        <= '0;
      active_q   <= 1'b0;
      armed_q    <= '0;
      tgt_on_q   <= '0;
      lvl_vld_q  <= '0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_acc && (in_i.func == tdc_pkg::FUNC_SELECT) && sel_ok) begin
        armed_q[sel_tube]  <= 1'b1;
        tgt_on_q[sel_tube] <= sel_on;
      end
      if (in_acc && (in_i.func == tdc_pkg::FUNC_TICK)) t_q <= '0;
      if (state_q == S_TUBE) begin
        c_q      <= '0;
        active_q <= 1'b0;
      end
      if (upd_go) begin
        lvl_vld_q[addr] <= 1'b1;
        if (nv_active) active_q <= 1'b1;
        if (!c_last) c_q <= c_q + CW'(1);
      end
      if (state_q == S_NEXT) begin
        if (!active_q) armed_q[t_q] <= 1'b0;
        if (!t_last) t_q <= t_q + TW'(1);
      end
      if (upd_go && stepped) begin
        pend_vld_q <= 1'b1;
      end else if ((state_q == S_FLUSH) && out_free) begin
        pend_vld_q <= 1'b0;
      end
      if (load_out) begin
        out_vld_q <= 1'b1;
      end else if (out_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && (in_i.func == tdc_pkg::FUNC_SELECT) && sel_ok) begin
      tgt_dig_q[sel_tube] <= CW'(in_i.digit);
      fade_q[sel_tube]    <= in_i.fade_time_us;
    end
    if ((state_q == S_DIV1) && div_rsp_i.done && (ticks == '0)) begin
      step_q <= range;
    end else if ((state_q == S_DIV2) && div_rsp_i.done) begin
      step_q <= div_rsp_i.quotient[LW-1:0];
    end
    if (state_q == S_RD) begin
      rd_data_q <= level_mem[addr];
      rd_vld_q  <= lvl_vld_q[addr];
    end
    if (upd_go) begin
      level_mem[addr] <= nv;
    end
    if (upd_go && stepped) begin
      pend_tube_q  <= tdc_pkg::TUBE_W'(t_q);
      pend_digit_q <= tdc_pkg::DIGIT_W'(c_q);
      pend_level_q <= nv;
    end
    if (load_out) begin
      out_tube_q  <= pend_tube_q;
      out_digit_q <= pend_digit_q;
      out_level_q <= pend_level_q;
      out_last_q  <= (state_q == S_FLUSH);
    end
  end

  assign out_o.valid     = out_vld_q;
  assign out_o.out_tube  = out_tube_q;
  assign out_o.out_digit = out_digit_q;
  assign out_o.level     = out_level_q;
  assign out_o.last      = out_last_q;

endmodule

@@ rtl/tube_digit_crossfade_top.sv @@
// ----------------------------------------------------------------------------
// Tube digit crossfade engine
// Top level: configuration registers, shared divider and the tick sequencer.
// ----------------------------------------------------------------------------
// A select request arms a tube with its new digit and fade time. A tick request
// walks all TUBE_COUNT tubes: an armed tube uses the shared 25-bit restoring
// divider, which yields one quotient bit per cycle, up to twice (fade over
// period, then the rounded-up step), followed by a read and a write of the
// level memory for every cathode. Results leave in tube and cathode order;
// the final one of a tick carries last. No request is accepted until the
// tick has finished.
module tube_digit_crossfade_top #(
  parameter int TUBE_COUNT    = tdc_pkg::TUBE_COUNT_DEF,
  parameter int CATHODE_COUNT = tdc_pkg::CATHODE_COUNT_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  tdc_in_if.sink                       in_i,
  tdc_out_if.source                    out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [tdc_pkg::PADDR_W-1:0]  paddr,
  input  logic [tdc_pkg::PDATA_W-1:0]  pwdata,
  output logic [tdc_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready
);

  tdc_pkg::cfg_t     cfg;
  tdc_pkg::div_req_t div_req;
  tdc_pkg::div_rsp_t div_rsp;

  tdc_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tdc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  tdc_seq #(
    .TUBE_COUNT    (TUBE_COUNT),
    .CATHODE_COUNT (CATHODE_COUNT)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg),
    .in_i      (in_i),
    .out_o     (out_o),
    .div_req_o (div_req),
    .div_rsp_i (div_rsp)
  );

endmodule

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// Tube digit crossfade testbench
// Drives select and tick requests into the crossfade engine, predicts every
// stepped cathode level with a shadow copy of the tube state, and checks the
// level results in order. Directed requests cover the register extremes and
// the corner cases. Random phases then vary the idling on both channels.
// ----------------------------------------------------------------------------
module tb_top;
  import tdc_pkg::*;

  localparam int TUBES        = TUBE_COUNT_DEF;
  localparam int CATHODES     = CATHODE_COUNT_DEF;
  // Covers a tick with four armed tubes that ends without any result.
  localparam int DRAIN_CYCLES = 400;
  localparam int CYCLE_LIMIT  = 3_000_000;

  typedef struct packed {
    logic               func;
    logic [TUBE_W-1:0]  tube;
    logic [DIGIT_W-1:0] digit;
    logic               blank;
    logic [FADE_W-1:0]  fade;
  } crossfade_req_t;

  typedef struct packed {
    logic [TUBE_W-1:0]  tube;
    logic [DIGIT_W-1:0] digit;
    logic [LEVEL_W-1:0] level;
    logic               last;
  } level_update_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               psel;
  logic               penable;
  logic               pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [PDATA_W-1:0] pwdata;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  tdc_in_if  in_ch ();
  tdc_out_if out_ch ();

  tube_digit_crossfade_top u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_ch),
    .out_o   (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the configuration and the tube state.
  logic [PERIOD_W-1:0] cfg_period;
  logic [LEVEL_W-1:0]  cfg_min;
  logic [LEVEL_W-1:0]  cfg_max;
  logic [LEVEL_W-1:0]  cath_level [TUBES*CATHODES];
  bit                  cath_rising [TUBES*CATHODES];
  logic [FADE_W-1:0]   tube_fade [TUBES];
  bit                  tube_armed [TUBES];

  level_update_t pending_levels [$];

  int     send_idle_pct  = 0;
  int     recv_stall_pct = 0;
  int     errors         = 0;
  int     n_selects      = 0;
  int     n_ticks        = 0;
  int     n_levels       = 0;
  int     n_configs      = 0;
  longint cycle_count    = 0;

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin : check_levels
    level_update_t got;
    level_update_t want;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.out_tube, out_ch.out_digit, out_ch.level, out_ch.last};
      if (pending_levels.size() == 0) begin
        $display("%0t: unexpected level: tube %0d cathode %0d level %0d last %0d",
                 $time, got.tube, got.digit, got.level, got.last);
        errors++;
      end else begin
        want = pending_levels.pop_front();
        n_levels++;
        if (got !== want) begin
          $display("%0t: level mismatch: expected tube %0d cathode %0d level %0d last %0d",
                   $time, want.tube, want.digit, want.level, want.last);
          $display("%0t:                 actual   tube %0d cathode %0d level %0d last %0d",
                   $time, got.tube, got.digit, got.level, got.last);
          errors++;
        end
      end
    end
  end

  function automatic int unsigned crossfade_step(input logic [FADE_W-1:0] fade);
    int unsigned per;
    int unsigned span;
    int unsigned ticks;
    per   = (cfg_period == 0) ? 1 : 32'(cfg_period);
    span  = (cfg_max > cfg_min) ? 32'(cfg_max - cfg_min) : 0;
    ticks = 32'(fade) / per;
    if (ticks == 0) return span;
    return (span + ticks - 1) / ticks;
  endfunction

  // Updates the shadow state for one accepted request and queues the levels
  // that a tick is expected to emit.
  task automatic apply_request(input crossfade_req_t r);
    level_update_t batch [$];
    level_update_t u;
    int unsigned   step;
    int unsigned   v;
    int            k;
    bit            moved;
    bit            active;
    if (r.func == FUNC_SELECT) begin
      n_selects++;
      if (r.tube >= TUBES) return;
      for (int c = 0; c < CATHODES; c++) cath_rising[r.tube*CATHODES + c] = 1'b0;
      if (!r.blank && r.digit < CATHODES) cath_rising[r.tube*CATHODES + r.digit] = 1'b1;
      tube_fade[r.tube]  = r.fade;
      tube_armed[r.tube] = 1'b1;
    end else begin
      n_ticks++;
      for (int t = 0; t < TUBES; t++) begin
        if (!tube_armed[t]) continue;
        step   = crossfade_step(tube_fade[t]);
        active = 1'b0;
        for (int c = 0; c < CATHODES; c++) begin
          k     = t*CATHODES + c;
          v     = 32'(cath_level[k]);
          moved = 1'b0;
          if (cath_rising[k]) begin
            if (v <= cfg_max) begin
              v     = (v + step >= cfg_max) ? cfg_max : v + step;
              moved = 1'b1;
            end
          end else if (v >= cfg_min) begin
            v     = (v <= cfg_min + step) ? cfg_min : v - step;
            moved = 1'b1;
          end
          cath_level[k] = LEVEL_W'(v);
          if (moved) begin
            u = '{TUBE_W'(t), DIGIT_W'(c), LEVEL_W'(v), 1'b0};
            batch.push_back(u);
          end
          if (v > cfg_min && v < cfg_max) active = 1'b1;
        end
        if (!active) tube_armed[t] = 1'b0;
      end
      if (batch.size() > 0) batch[$].last = 1'b1;
      foreach (batch[i]) pending_levels.push_back(batch[i]);
    end
  endtask

  // Called at a clock edge. Leaves valid high after acceptance so that a
  // back-to-back request never lowers and raises it in the same step.
  task automatic send_req(input crossfade_req_t r);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.func         <= r.func;
    in_ch.tube         <= r.tube;
    in_ch.digit        <= r.digit;
    in_ch.blank        <= r.blank;
    in_ch.fade_time_us <= r.fade;
    do @(posedge clk_i); while (!in_ch.ready);
    apply_request(r);
  endtask

  task automatic send_tick();
    send_req('{FUNC_TICK, '0, '0, 1'b0, '0});
  endtask

  task automatic send_select(input int tube, input int digit, input bit blank,
                             input logic [FADE_W-1:0] fade);
    send_req('{FUNC_SELECT, TUBE_W'(tube), DIGIT_W'(digit), blank, fade});
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (pending_levels.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic reg_write(input logic [1:0] idx, input logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic set_config(input logic [PERIOD_W-1:0] per, input logic [LEVEL_W-1:0] lo,
                            input logic [LEVEL_W-1:0] hi);
    wait_idle();
    reg_write(REG_PERIOD, PDATA_W'(per));
    reg_write(REG_LEVEL_MIN, PDATA_W'(lo));
    reg_write(REG_LEVEL_MAX, PDATA_W'(hi));
    cfg_period = per;
    cfg_min    = lo;
    cfg_max    = hi;
    n_configs++;
  endtask

  function automatic crossfade_req_t random_request();
    crossfade_req_t r;
    int unsigned    per;
    r   = crossfade_req_t'($urandom());
    per = (cfg_period == 0) ? 1 : 32'(cfg_period);
    if ($urandom_range(0, 99) < 30) begin
      r.func  = FUNC_SELECT;
      r.blank = ($urandom_range(0, 9) == 0);
      r.digit = ($urandom_range(0, 7) == 0) ? DIGIT_W'($urandom_range(10, 15)) :
                                               DIGIT_W'($urandom_range(0, 9));
      case ($urandom_range(0, 9))
        0:       r.fade = FADE_W'($urandom());
        1:       r.fade = '0;
        default: r.fade = FADE_W'(per*$urandom_range(1, 12) + $urandom_range(0, per - 1));
      endcase
    end else begin
      r.func = FUNC_TICK;
    end
    return r;
  endfunction

  task automatic test_empty_tick();
    send_tick();
  endtask

  // Zero fade time jumps straight to the end levels; the tube then disarms.
  task automatic test_instant_fade();
    send_select(0, 9, 1'b0, '0);
    send_tick();
    send_tick();
  endtask

  task automatic test_blank_and_crossfade();
    send_select(1, 15, 1'b0, 24'd3000);
    send_select(2, 0, 1'b0, 24'd3000);
    send_select(3, 5, 1'b1, 24'hFFFFFF);
    repeat (4) send_tick();
    send_select(2, 7, 1'b0, 24'd2500);
    repeat (3) send_tick();
  endtask

  task automatic test_register_extremes();
    set_config(16'd0, 12'd0, 12'd4095);
    send_select(0, 3, 1'b0, 24'd5);
    repeat (2) send_tick();
    set_config(16'd65535, 12'd0, 12'd4095);
    send_select(1, 1, 1'b0, 24'hFFFFFF);
    send_tick();
    // An empty range gives a zero step.
    set_config(16'd65535, 12'd0, 12'd0);
    send_tick();
    set_config(16'd1, 12'd4095, 12'd4095);
    send_select(0, 3, 1'b0, '0);
    send_tick();
    // A rising level above the window or a falling one below it is neither stepped nor reported.
    set_config(16'd1, 12'd200, 12'd300);
    send_select(0, 3, 1'b0, '0);
    send_tick();
    send_select(1, 0, 1'b0, '0);
    send_tick();
  endtask

  task automatic test_random_phase(input int n_reqs, input int send_pct, input int recv_pct,
                                   input logic [PERIOD_W-1:0] per,
                                   input logic [LEVEL_W-1:0] lo, input logic [LEVEL_W-1:0] hi);
    set_config(per, lo, hi);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (n_reqs) send_req(random_request());
  endtask

  initial begin
    int lo;
    rst_ni             = 1'b0;
    psel               = 1'b0;
    penable            = 1'b0;
    pwrite             = 1'b0;
    paddr              = '0;
    pwdata             = '0;
    in_ch.valid        = 1'b0;
    in_ch.func         = FUNC_TICK;
    in_ch.tube         = '0;
    in_ch.digit        = '0;
    in_ch.blank        = 1'b0;
    in_ch.fade_time_us = '0;
    out_ch.ready       = 1'b0;
    cfg_period         = PERIOD_RST;
    cfg_min            = LEVEL_MIN_RST;
    cfg_max            = LEVEL_MAX_RST;
    foreach (cath_level[i]) begin
      cath_level[i]  = '0;
      cath_rising[i] = 1'b0;
    end
    foreach (tube_fade[i]) begin
      tube_fade[i]  = '0;
      tube_armed[i] = 1'b0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_empty_tick();
    test_instant_fade();
    test_blank_and_crossfade();
    test_register_extremes();

    test_random_phase(120, 0, 0, 16'd1, 12'd0, 12'd4095);
    lo = $urandom_range(0, 2000);
    test_random_phase(120, 88, 0, PERIOD_W'($urandom_range(1, 5000)), LEVEL_W'(lo),
                      LEVEL_W'($urandom_range(lo + 1, 4095)));
    test_random_phase(120, 0, 88, 16'd65535, 12'd0, 12'd4095);
    lo = $urandom_range(0, 2000);
    test_random_phase(110, 8, 8, 16'd0, LEVEL_W'(lo), LEVEL_W'($urandom_range(lo + 1, 4095)));

    wait_idle();
    errors += pending_levels.size();
    $display("Covered %0d selects and %0d ticks over %0d register settings,", n_selects,
             n_ticks, n_configs);
    $display("with %0d level results checked and %0d errors.", n_levels, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
